>>> rtl/amsp_pkg.sv
// Package for the MGT section parser: item types for the byte and record
// channels and the record kind codes. No dependencies.
package amsp_pkg;

   localparam logic [1:0] KIND_HEADER  = 2'd0;
   localparam logic [1:0] KIND_ENTRY   = 2'd1;
   localparam logic [1:0] KIND_TRAILER = 2'd2;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       section_start;
   } req_type;

   typedef struct packed {
      logic [1:0]  record_kind;
      logic [7:0]  table_id;
      logic [11:0] section_length;
      logic [15:0] table_id_extension;
      logic [4:0]  version_number;
      logic        current_next;
      logic [7:0]  section_number;
      logic [7:0]  last_section_number;
      logic [7:0]  protocol_version;
      logic [15:0] count_or_type;
      logic [12:0] entry_pid;
      logic [31:0] wide_value;
   } rsp_type;

endpackage

>>> rtl/atsc_mgt_section_parser_top.sv
// MGT section parser top level: byte-wise section walker with a record
// output register. Depends on amsp_pkg.
//
// Usage:
//  - req channel: one section byte per item; section_start marks the table id
//    byte and restarts the parse from any state.
//  - rsp channel: header record after the 11th header byte, one entry record
//    after each entry's descriptor length, a trailer record after the CRC.
//    Fields that do not apply to a record kind are zero.
//  - Records: a record is valid the cycle after the byte that completes it.
//  - Throughput: one byte per cycle while req_ready is high; the only state
//    update per byte is a shift or a 16-bit or 12-bit decrement in the phase logic.
//  - Stall: the single output register holds a record until taken; req_ready
//    falls only while that register is full and rsp_ready is low.
//  - Reset: parser idle, bytes ignored until a section start; output empty.
module atsc_mgt_section_parser_top
   import amsp_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   typedef enum logic [3:0] {
      PH_IDLE,
      PH_HEADER,
      PH_ENTRY,
      PH_ENTRY_SKIP,
      PH_GLOBAL_LEN,
      PH_GLOBAL_SKIP,
      PH_CRC,
      PH_DONE
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [3:0]  byte_position_ff, byte_position_in;
   logic [31:0] field_shift_ff, field_shift_in;
   logic [15:0] entries_left_ff, entries_left_in;
   logic [11:0] skip_left_ff, skip_left_in;
   logic [63:0] header_hold_ff, header_hold_in;
   logic [39:0] entry_hold_ff, entry_hold_in;
   logic [7:0]  table_id_ff, table_id_in;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_data_ff, rsp_data_in;

   logic        req_fire;
   logic        emit;
   rsp_type     rec;
   logic [7:0]  b;
   logic [11:0] skip_new;
   logic [11:0] skip_dec;
   logic [15:0] entries_dec;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign b           = req_data.data_byte;
   assign skip_new    = {skip_left_ff[3:0], b};
   assign skip_dec    = skip_left_ff - 12'd1;
   assign entries_dec = entries_left_ff - 16'd1;

   always_comb begin
      phase_in         = phase_ff;
      byte_position_in = byte_position_ff;
      field_shift_in   = field_shift_ff;
      entries_left_in  = entries_left_ff;
      skip_left_in     = skip_left_ff;
      header_hold_in   = header_hold_ff;
      entry_hold_in    = entry_hold_ff;
      table_id_in      = table_id_ff;
      emit             = 1'b0;
      rec              = '0;

      if (req_fire) begin
         if (req_data.section_start) begin
            table_id_in      = b;
            header_hold_in   = '0;
            field_shift_in   = '0;
            entries_left_in  = '0;
            skip_left_in     = '0;
            entry_hold_in    = '0;
            byte_position_in = 4'd1;
            phase_in         = PH_HEADER;
         end else begin
            unique case (phase_ff)
               PH_HEADER: begin
                  if (byte_position_ff <= 4'd8) begin
                     header_hold_in   = {header_hold_ff[55:0], b};
                     byte_position_in = byte_position_ff + 4'd1;
                  end else if (byte_position_ff == 4'd9) begin
                     field_shift_in   = {24'd0, b};
                     byte_position_in = byte_position_ff + 4'd1;
                  end else begin
                     emit                    = 1'b1;
                     rec.record_kind         = KIND_HEADER;
                     rec.table_id            = table_id_ff;
                     rec.section_length      = header_hold_ff[59:48];
                     rec.table_id_extension  = header_hold_ff[47:32];
                     rec.version_number      = header_hold_ff[29:25];
                     rec.current_next        = header_hold_ff[24];
                     rec.section_number      = header_hold_ff[23:16];
                     rec.last_section_number = header_hold_ff[15:8];
                     rec.protocol_version    = header_hold_ff[7:0];
                     rec.count_or_type       = {field_shift_ff[7:0], b};
                     entries_left_in         = {field_shift_ff[7:0], b};
                     field_shift_in          = '0;
                     byte_position_in        = '0;
                     phase_in = ({field_shift_ff[7:0], b} != 16'd0) ? PH_ENTRY
                                                                    : PH_GLOBAL_LEN;
                  end
               end
               PH_ENTRY: begin
                  if (byte_position_ff <= 4'd4) begin
                     // type, pid, version byte
                     entry_hold_in    = {entry_hold_ff[31:0], b};
                     byte_position_in = byte_position_ff + 4'd1;
                     if (byte_position_ff == 4'd4)
                        field_shift_in = '0;
                  end else if (byte_position_ff <= 4'd8) begin
                     field_shift_in   = {field_shift_ff[23:0], b};
                     byte_position_in = byte_position_ff + 4'd1;
                  end else if (byte_position_ff == 4'd9) begin
                     skip_left_in     = {4'd0, b};
                     byte_position_in = byte_position_ff + 4'd1;
                  end else begin
                     emit               = 1'b1;
                     rec.record_kind    = KIND_ENTRY;
                     rec.version_number = entry_hold_ff[5:1];
                     rec.count_or_type  = entry_hold_ff[39:24];
                     rec.entry_pid      = entry_hold_ff[20:8];
                     rec.wide_value     = field_shift_ff;
                     skip_left_in       = skip_new;
                     entries_left_in    = entries_dec;
                     entry_hold_in      = '0;
                     if (skip_new != 12'd0) begin
                        phase_in = PH_ENTRY_SKIP;
                     end else begin
                        phase_in = (entries_dec != 16'd0) ? PH_ENTRY : PH_GLOBAL_LEN;
                        byte_position_in = '0;
                        field_shift_in   = '0;
                     end
                  end
               end
               PH_ENTRY_SKIP: begin
                  skip_left_in = skip_dec;
                  if (skip_dec == 12'd0) begin
                     phase_in = (entries_left_ff != 16'd0) ? PH_ENTRY : PH_GLOBAL_LEN;
                     byte_position_in = '0;
                     field_shift_in   = '0;
                  end
               end
               PH_GLOBAL_LEN: begin
                  if (byte_position_ff == 4'd0) begin
                     skip_left_in     = {4'd0, b};
                     byte_position_in = 4'd1;
                  end else begin
                     skip_left_in     = skip_new;
                     byte_position_in = '0;
                     field_shift_in   = '0;
                     phase_in = (skip_new != 12'd0) ? PH_GLOBAL_SKIP : PH_CRC;
                  end
               end
               PH_GLOBAL_SKIP: begin
                  skip_left_in = skip_dec;
                  if (skip_dec == 12'd0) begin
                     phase_in         = PH_CRC;
                     byte_position_in = '0;
                     field_shift_in   = '0;
                  end
               end
               PH_CRC: begin
                  field_shift_in   = {field_shift_ff[23:0], b};
                  byte_position_in = byte_position_ff + 4'd1;
                  if (byte_position_ff == 4'd3) begin
                     emit             = 1'b1;
                     rec.record_kind  = KIND_TRAILER;
                     rec.wide_value   = {field_shift_ff[23:0], b};
                     phase_in         = PH_DONE;
                     byte_position_in = '0;
                  end
               end
               PH_IDLE, PH_DONE: begin
               end
               default: begin
               end
            endcase
         end
      end

      if (req_fire)
         rsp_valid_in = emit;
      else if (rsp_ready)
         rsp_valid_in = 1'b0;
      else
         rsp_valid_in = rsp_valid_ff;

      rsp_data_in = (req_fire && emit) ? rec : rsp_data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= PH_IDLE;
         byte_position_ff <= '0;
         field_shift_ff   <= '0;
         entries_left_ff  <= '0;
         skip_left_ff     <= '0;
         header_hold_ff   <= '0;
         entry_hold_ff    <= '0;
         table_id_ff      <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         phase_ff         <= phase_in;
         byte_position_ff <= byte_position_in;
         field_shift_ff   <= field_shift_in;
         entries_left_ff  <= entries_left_in;
         skip_left_ff     <= skip_left_in;
         header_hold_ff   <= header_hold_in;
         entry_hold_ff    <= entry_hold_in;
         table_id_ff      <= table_id_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

`ifndef ASSERT_OFF
   a_start_restarts: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_data.section_start) |=>
         (phase_ff == PH_HEADER && byte_position_ff == 4'd1))
      else $error("section start did not restart header parse");

   a_new_record_needs_item: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(req_fire))
      else $error("record appeared without an accepted item");

   a_skip_nonzero: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_ENTRY_SKIP || phase_ff == PH_GLOBAL_SKIP) |->
         (skip_left_ff != 12'd0))
      else $error("skip phase with zero count");

   a_trailer_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.record_kind == KIND_TRAILER) |->
         (rsp_data_ff.entry_pid == 13'd0 && rsp_data_ff.count_or_type == 16'd0))
      else $error("trailer record carries entry fields");

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid_ff)
      else $error("input stalled with empty output register");
`endif

endmodule

>>> tb/sv/testbench.sv
// Self-checking testbench for the MGT section parser: drives section bytes,
// predicts header, entry and trailer records, and checks them as they leave.
// Depends on amsp_pkg and atsc_mgt_section_parser_top.
module testbench
   import amsp_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int STALL_LIMIT = 2000;
   localparam int HOLD_CYCLES = 300;

   typedef enum logic [3:0] {
      WALK_IDLE, WALK_HEADER, WALK_ENTRY, WALK_DESC_SKIP,
      WALK_GLOBAL_LEN, WALK_GLOBAL_SKIP, WALK_CRC, WALK_DONE
   } walk_phase_type;

   logic    clock;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   atsc_mgt_section_parser_top dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   // parser state mirrored by the predictor
   walk_phase_type walk_phase = WALK_IDLE;
   logic [3:0]  walk_pos = '0;
   logic [31:0] walk_shift = '0;
   logic [15:0] entries_pending = '0;
   logic [11:0] skip_count = '0;
   logic [63:0] header_bytes = '0;
   logic [39:0] entry_bytes = '0;
   logic [7:0]  table_id_seen = '0;

   req_type byte_queue[$];
   rsp_type record_queue[$];
   int      bytes_queued = 0;
   int      mismatches = 0;
   int      send_idle_pct = 16;
   int      recv_idle_pct = 49;
   int      hold_requests = 0;
   int      holds_taken = 0;
   int      hold_left = 0;
   int      stall_cycles = 0;
   rsp_type predicted;
   rsp_type record_want;
   bit      has_record;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic void next_entry_or_global();
      if (entries_pending != 0) begin
         walk_phase = WALK_ENTRY;
      end else begin
         walk_phase = WALK_GLOBAL_LEN;
      end
      walk_pos = '0;
      walk_shift = '0;
   endfunction

   function automatic bit decode_mgt_byte(input req_type item, output rsp_type rec);
      logic [7:0] b;
      b = item.data_byte;
      rec = '0;
      if (item.section_start) begin
         table_id_seen = b;
         header_bytes = '0;
         walk_shift = '0;
         entries_pending = '0;
         skip_count = '0;
         entry_bytes = '0;
         walk_pos = 4'd1;
         walk_phase = WALK_HEADER;
         return 1'b0;
      end
      case (walk_phase)
         WALK_HEADER: begin
            if (walk_pos <= 8) begin
               header_bytes = {header_bytes[55:0], b};
               walk_pos++;
               return 1'b0;
            end
            walk_shift = {16'h0, walk_shift[7:0], b};
            if (walk_pos == 9) begin
               walk_pos++;
               return 1'b0;
            end
            rec.record_kind = KIND_HEADER;
            rec.table_id = table_id_seen;
            rec.section_length = header_bytes[59:48];
            rec.table_id_extension = header_bytes[47:32];
            rec.version_number = header_bytes[29:25];
            rec.current_next = header_bytes[24];
            rec.section_number = header_bytes[23:16];
            rec.last_section_number = header_bytes[15:8];
            rec.protocol_version = header_bytes[7:0];
            rec.count_or_type = walk_shift[15:0];
            entries_pending = walk_shift[15:0];
            next_entry_or_global();
            return 1'b1;
         end
         WALK_ENTRY: begin
            // type, pid and version bytes first, then byte count, then desc length
            if (walk_pos <= 4) begin
               entry_bytes = {entry_bytes[31:0], b};
               walk_pos++;
               if (walk_pos == 5) walk_shift = '0;
               return 1'b0;
            end
            if (walk_pos <= 8) begin
               walk_shift = {walk_shift[23:0], b};
               walk_pos++;
               return 1'b0;
            end
            if (walk_pos == 9) begin
               skip_count = {4'h0, b};
               walk_pos++;
               return 1'b0;
            end
            skip_count = {skip_count[3:0], b};
            rec.record_kind = KIND_ENTRY;
            rec.version_number = entry_bytes[5:1];
            rec.count_or_type = entry_bytes[39:24];
            rec.entry_pid = entry_bytes[20:8];
            rec.wide_value = walk_shift;
            entries_pending--;
            entry_bytes = '0;
            if (skip_count != 0) begin
               walk_phase = WALK_DESC_SKIP;
            end else begin
               next_entry_or_global();
            end
            return 1'b1;
         end
         WALK_DESC_SKIP: begin
            skip_count--;
            if (skip_count == 0) next_entry_or_global();
            return 1'b0;
         end
         WALK_GLOBAL_LEN: begin
            if (walk_pos == 0) begin
               skip_count = {4'h0, b};
               walk_pos = 4'd1;
               return 1'b0;
            end
            skip_count = {skip_count[3:0], b};
            walk_pos = '0;
            walk_shift = '0;
            if (skip_count != 0) begin
               walk_phase = WALK_GLOBAL_SKIP;
            end else begin
               walk_phase = WALK_CRC;
            end
            return 1'b0;
         end
         WALK_GLOBAL_SKIP: begin
            skip_count--;
            if (skip_count == 0) begin
               walk_phase = WALK_CRC;
               walk_pos = '0;
               walk_shift = '0;
            end
            return 1'b0;
         end
         WALK_CRC: begin
            walk_shift = {walk_shift[23:0], b};
            walk_pos++;
            if (walk_pos < 4) return 1'b0;
            rec.record_kind = KIND_TRAILER;
            rec.wide_value = walk_shift;
            walk_phase = WALK_DONE;
            walk_pos = '0;
            return 1'b1;
         end
         default: return 1'b0;
      endcase
   endfunction

   function automatic req_type section_byte(input logic start, input logic [7:0] value);
      req_type item;
      item.data_byte = value;
      item.section_start = start;
      return item;
   endfunction

   // fill < 0 gives random content
   function automatic logic [7:0] fill_byte(input int fill);
      if (fill < 0) return 8'($urandom_range(255));
      return 8'(fill);
   endfunction

   task automatic queue_section(input int count, input int max_desc, input int max_glen,
                                input int fill, input bit cut, input int junk);
      req_type    sec[$];
      int         n_build, dlen, cut_at, i, k;
      logic [7:0] hi;
      sec = {sec, section_byte(1'b1, fill_byte(fill))};
      for (i = 0; i < 8; i++) sec = {sec, section_byte(1'b0, fill_byte(fill))};
      sec = {sec, section_byte(1'b0, count[15:8])};
      sec = {sec, section_byte(1'b0, count[7:0])};
      n_build = (cut && count > 3) ? 3 : count;
      for (k = 0; k <= n_build; k++) begin
         // the pass after the last entry builds the global descriptor loop
         if (k < n_build) begin
            for (i = 0; i < 9; i++) sec = {sec, section_byte(1'b0, fill_byte(fill))};
            dlen = $urandom_range(max_desc, 0);
         end else begin
            dlen = $urandom_range(max_glen, 0);
         end
         hi = fill_byte(fill);
         sec = {sec, section_byte(1'b0, {hi[7:4], dlen[11:8]})};
         sec = {sec, section_byte(1'b0, dlen[7:0])};
         for (i = 0; i < dlen; i++) sec = {sec, section_byte(1'b0, fill_byte(fill))};
      end
      for (i = 0; i < 4; i++) sec = {sec, section_byte(1'b0, fill_byte(fill))};
      if (cut) begin
         cut_at = $urandom_range(sec.size() - 1, 1);
         while (sec.size() > cut_at) void'(sec.pop_back());
      end else begin
         for (i = 0; i < junk; i++)
            sec = {sec, section_byte(1'b0, 8'($urandom_range(255)))};
      end
      byte_queue = {byte_queue, sec};
      bytes_queued += sec.size();
   endtask

   task automatic queue_random_traffic(input int n_bytes);
      int target, pick, n, i;
      target = bytes_queued + n_bytes;
      while (bytes_queued < target) begin
         pick = $urandom_range(99);
         if (pick < 80) begin
            queue_section($urandom_range(3, 0), ($urandom_range(19) == 0) ? 300 : 4, 4, -1,
                          1'b0, $urandom_range(2, 0));
         end else if (pick < 90) begin
            queue_section($urandom_range(4, 0), 4, 4, -1, 1'b1, 0);
         end else begin
            n = $urandom_range(6, 1);
            for (i = 0; i < n; i++)
               byte_queue = {byte_queue, section_byte($urandom_range(3) == 0,
                                                      8'($urandom_range(255)))};
            bytes_queued += n;
         end
      end
   endtask

   task automatic wait_drained();
      do @(negedge clock);
      while (byte_queue.size() != 0 || req_valid || record_queue.size() != 0);
   endtask

   task automatic check_field(input string field, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s expected 0x%0h, got 0x%0h", $time, field, want, got);
         mismatches++;
      end
   endtask

   // byte sender
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            has_record = decode_mgt_byte(req_data, predicted);
            if (has_record) record_queue = {record_queue, predicted};
         end
         if (!req_valid || req_ready) begin
            if (byte_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_valid <= 1'b1;
               req_data <= byte_queue.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // record receiver, with an occasional long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (holds_taken != hold_requests) begin
         holds_taken <= holds_taken + 1;
         hold_left <= HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (record_queue.size() == 0) begin
            $display("%0t: record kind %0d arrived with nothing expected", $time,
                     rsp_data.record_kind);
            mismatches++;
         end else begin
            record_want = record_queue.pop_front();
            check_field("record_kind", 32'(record_want.record_kind),
                        32'(rsp_data.record_kind));
            check_field("table_id", 32'(record_want.table_id), 32'(rsp_data.table_id));
            check_field("section_length", 32'(record_want.section_length),
                        32'(rsp_data.section_length));
            check_field("table_id_extension", 32'(record_want.table_id_extension),
                        32'(rsp_data.table_id_extension));
            check_field("version_number", 32'(record_want.version_number),
                        32'(rsp_data.version_number));
            check_field("current_next", 32'(record_want.current_next),
                        32'(rsp_data.current_next));
            check_field("section_number", 32'(record_want.section_number),
                        32'(rsp_data.section_number));
            check_field("last_section_number", 32'(record_want.last_section_number),
                        32'(rsp_data.last_section_number));
            check_field("protocol_version", 32'(record_want.protocol_version),
                        32'(rsp_data.protocol_version));
            check_field("count_or_type", 32'(record_want.count_or_type),
                        32'(rsp_data.count_or_type));
            check_field("entry_pid", 32'(record_want.entry_pid), 32'(rsp_data.entry_pid));
            check_field("wide_value", record_want.wide_value, rsp_data.wide_value);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles == STALL_LIMIT) begin
         $display("%0t: no item accepted for %0d cycles", $time, STALL_LIMIT);
         $display("Verification failed");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // stray bytes while idle are dropped
      byte_queue = {byte_queue, section_byte(1'b0, 8'h00)};
      byte_queue = {byte_queue, section_byte(1'b0, 8'hFF)};
      byte_queue = {byte_queue, section_byte(1'b0, 8'h5A)};
      // all zeros: no entries, no global descriptors, junk after the crc
      queue_section(0, 0, 0, 8'h00, 1'b0, 2);
      // all ones, reserved bits set in the length fields
      queue_section(1, 2, 2, 8'hFF, 1'b0, 0);
      queue_section(2, 3, 3, -1, 1'b0, 0);
      // maximum entry count, restarted mid-section
      queue_section(16'hFFFF, 2, 2, -1, 1'b1, 0);
      queue_section(3, 4, 4, -1, 1'b1, 0);
      wait_drained();
      queue_random_traffic(80);
      wait_drained();

      send_idle_pct = 49;
      recv_idle_pct = 16;
      queue_random_traffic(80);
      wait_drained();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      queue_section(3, 4, 4, -1, 1'b0, 0);
      queue_section(3, 4, 4, -1, 1'b0, 0);
      queue_section(3, 4, 4, -1, 1'b0, 0);
      hold_requests++;
      queue_random_traffic(50);
      wait_drained();

      repeat (10) @(posedge clock);
      if (mismatches == 0 && record_queue.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

>>> files.f
rtl/amsp_pkg.sv
rtl/atsc_mgt_section_parser_top.sv
tb/sv/testbench.sv
